/* rtl/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/atzr_pkg.sv */
// ----------------------------------------------------------------------------
// atzr_pkg
// Shared sizes, fixed-point constants, payload types and command codes of the
// ascii torus renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package atzr_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 22;
  localparam int RING_STEPS  = 90;
  localparam int SWEEP_STEPS = 314;
  localparam int ANGLE_BITS  = 12;

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int RING_W  = $clog2(RING_STEPS);
  localparam int SWEEP_W = $clog2(SWEEP_STEPS);

  localparam int QUARTER_BITS = ANGLE_BITS - 2;
  localparam int U_SHIFT      = 16 - QUARTER_BITS;

  localparam int RING_INC      = (1 << ANGLE_BITS) / RING_STEPS;
  localparam int RING_REM_INC  = (1 << ANGLE_BITS) % RING_STEPS;
  localparam int SWEEP_INC     = (1 << ANGLE_BITS) / SWEEP_STEPS;
  localparam int SWEEP_REM_INC = (1 << ANGLE_BITS) % SWEEP_STEPS;

  localparam int VW       = 24;
  localparam int PW       = 2 * VW;
  localparam int POS_SHIFT = 30;
  localparam int POS_W    = PW - POS_SHIFT;
  localparam int DEPTH_W  = 16;
  localparam int DEN_W    = VW - 1;
  localparam int DIV_BITS = 31;
  localparam int LEVEL_W  = 4;
  localparam int CHAR_W   = 7;
  localparam int CFG_W    = ANGLE_BITS;

  localparam int ONE_Q14      = 16384;
  localparam int X_CENTER     = 40;
  localparam int X_SCALE      = 30;
  localparam int Y_CENTER     = 12;
  localparam int Y_SCALE      = 15;
  localparam int DEPTH_OFFSET = 5;
  localparam int LEVEL_SHIFT  = 11;
  localparam int LEVEL_MAX    = 11;

  localparam int SIN_K0 = 4926;
  localparam int SIN_K1 = 42334;
  localparam int SIN_K2 = 102944;

  localparam logic OPER_RENDER = 1'b0;
  localparam logic OPER_READ   = 1'b1;

  typedef enum logic [0:0] {
    REG_ROTATION_A = 1'b0,
    REG_ROTATION_B = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic        operation;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [3:0] shade_level;
  } out_item_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_CLEAR, OP_READ, OP_EMIT,
    OP_SIN0, OP_SIN1, OP_SIN2, OP_SIN3, OP_SIN4,
    OP_RING_START, OP_RING_STEP, OP_RING_PROD0, OP_RING_PROD1,
    OP_SWEEP_START, OP_SWEEP_STEP,
    OP_CH, OP_CD, OP_LH, OP_DEN, OP_T, OP_TN, OP_PX, OP_TM, OP_PY,
    OP_L1, OP_L2, OP_L3, OP_L4, OP_L5, OP_L6, OP_L7, OP_L8,
    OP_XP, OP_X, OP_YP, OP_Y, OP_LOOK, OP_WRITE
  } op_t;

  typedef enum logic [2:0] {
    TGT_E, TGT_G, TGT_N, TGT_M, TGT_D, TGT_F, TGT_C, TGT_L
  } tgt_t;

  typedef struct packed {
    op_t  op;
    tgt_t tgt;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_busy;
    logic keep;
  } status_t;

  function automatic logic [CHAR_W-1:0] shade_char(input logic [LEVEL_W-1:0] lvl);
    logic [CHAR_W-1:0] ch;
    case (lvl)
      4'd1:    ch = 7'h2E;
      4'd2:    ch = 7'h2C;
      4'd3:    ch = 7'h2D;
      4'd4:    ch = 7'h7E;
      4'd5:    ch = 7'h3A;
      4'd6:    ch = 7'h3B;
      4'd7:    ch = 7'h3D;
      4'd8:    ch = 7'h21;
      4'd9:    ch = 7'h2A;
      4'd10:   ch = 7'h23;
      4'd11:   ch = 7'h24;
      4'd12:   ch = 7'h40;
      default: ch = 7'h20;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/ascii_torus_zbuffer_render_top.sv */
// ----------------------------------------------------------------------------
// ascii_torus_zbuffer_render_top
// Renders a spinning torus into an 80x22 shade store with a depth test and
// answers single-cell character reads.
//
//   channel   dir   handshake            beat
//   in        in    in_valid/in_ready    operation, cell_index
//   out       out   out_valid/out_ready  char_code, shade_level
//   cfg       in    cfg_write            cfg_index, cfg_data
//
// read: shade read on accept, out_valid registered from ST_READ, one read in flight
// render: clear of all 1760 store cells, then one surface point after another
//   (90 x 314 points), paced by the 31-bit serial reciprocal divider
// after reset all 1760 cells of the stores are cleared with in_ready low
// in_ready also stays low while a result beat is stalled and not taken
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_torus_zbuffer_render_top import atzr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_write,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  atzr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_operation (in_data.operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd          (cmd)
  );

  atzr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/atzr_div.sv */
// ----------------------------------------------------------------------------
// atzr_div
// Restoring divider, one quotient bit per cycle: 2^30 / divisor, saturated
// to the 16-bit depth range.
// ----------------------------------------------------------------------------
`default_nettype none

module atzr_div import atzr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DEN_W-1:0]   divisor,
  output logic                    busy,
  output logic [DEPTH_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_BITS);
  localparam int RW    = DEN_W + 1;

  logic [DEN_W-1:0]    dsr;
  logic [RW-1:0]       rem;
  logic [DIV_BITS-1:0] quo;
  logic [CNT_W-1:0]    cnt;
  logic [RW-1:0]       rem_sh;
  logic                fits;

  always_comb begin
    rem_sh = {rem[RW-2:0], (cnt == CNT_W'(DIV_BITS - 1))};
    fits   = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
      cnt <= CNT_W'(DIV_BITS - 1);
    end else if (busy) begin
      rem <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
      quo <= {quo[DIV_BITS-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = (quo[DIV_BITS-1:DEPTH_W] != '0) ? '1 : quo[DEPTH_W-1:0];

endmodule

`default_nettype wire

/* rtl/atzr_datapath.sv */
// ----------------------------------------------------------------------------
// atzr_datapath
// Fixed-point datapath: shared multiplier, sine evaluation, projection,
// lighting, the depth and shade stores and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atzr_datapath import atzr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_write,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output out_item_t                 out_data
);

  localparam int RR_W = $clog2(RING_STEPS);
  localparam int SR_W = $clog2(SWEEP_STEPS);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << QUARTER_BITS);
  localparam logic [QUARTER_BITS:0] QUARTER_V = (QUARTER_BITS+1)'(1 << QUARTER_BITS);
  localparam logic signed [PW-1:0] ROUND_Q14 = PW'(8192);
  localparam logic signed [VW-1:0] ONE_V   = VW'(ONE_Q14);
  localparam logic signed [VW-1:0] TWO_V   = VW'(2 * ONE_Q14);
  localparam logic signed [VW-1:0] DEN_OFF = VW'(DEPTH_OFFSET * ONE_Q14);
  localparam logic signed [VW-1:0] K0 = VW'(SIN_K0);
  localparam logic signed [VW-1:0] K1 = VW'(SIN_K1);
  localparam logic signed [VW-1:0] K2 = VW'(SIN_K2);
  localparam logic signed [PW-1:0] X_BIAS = PW'(X_CENTER) << POS_SHIFT;
  localparam logic signed [PW-1:0] Y_BIAS = PW'(Y_CENTER) << POS_SHIFT;
  localparam logic signed [PW-1:0] X_MUL  = PW'(X_SCALE);
  localparam logic signed [PW-1:0] Y_MUL  = PW'(Y_SCALE);
  localparam logic signed [POS_W-1:0] X_LIM = POS_W'(COLUMNS);
  localparam logic signed [POS_W-1:0] Y_LIM = POS_W'(ROWS);
  localparam logic signed [VW-1:0] LVL_MAX = VW'(LEVEL_MAX);

  logic [ANGLE_BITS-1:0] rot_a, rot_b;
  logic [ANGLE_BITS-1:0] ring_ph, sweep_ph;
  logic [RR_W-1:0]       ring_rem;
  logic [SR_W-1:0]       sweep_rem;
  logic [CELL_W-1:0]     clr_addr;

  logic signed [VW-1:0] e, g, n, m, d, f, h, fe, fg, c, l;
  logic signed [VW-1:0] ch, cd, lh, den, t, ta, px, py, la, lb;
  logic signed [VW-1:0] su, su2, sv;
  logic [1:0]           squad;
  logic signed [PW-1:0] xp, yp;
  logic signed [POS_W-1:0] x, y;

  logic [DEPTH_W-1:0] depth_mem [CELLS];
  logic [LEVEL_W-1:0] shade_mem [CELLS];
  logic [DEPTH_W-1:0] depth_q;
  logic [LEVEL_W-1:0] shade_q;
  logic               oor_q;
  logic               onscreen_q;
  logic [CELL_W-1:0]  cell_q;
  logic [LEVEL_W-1:0] lvl_q;

  logic [DEPTH_W-1:0] dq;
  logic               div_busy;

  logic signed [VW-1:0] ma, mb, qm, den_sum, sin_val, sin_r2, lum, lum_sh, lvl_idx;
  logic signed [PW-1:0] prod, qm_full, sin_res, x_sum, y_sum;
  logic [ANGLE_BITS-1:0] sin_phase;
  logic [QUARTER_BITS:0] sin_q;
  logic signed [VW-1:0]  sin_u;
  logic                  onscreen;
  logic [CELL_W-1:0]     look_addr, rd_addr;
  logic                  rd_oor;
  logic [RR_W:0]         ring_sum;
  logic [SR_W:0]         sweep_sum;
  logic [LEVEL_W-1:0]    lvl_out;

  atzr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_T),
    .divisor  (den[DEN_W-1:0]),
    .busy     (div_busy),
    .quotient (dq)
  );

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_SIN1:       begin ma = su;  mb = su;  end
      OP_SIN2:       begin ma = K0;  mb = su2; end
      OP_SIN3:       begin ma = su2; mb = sv;  end
      OP_SIN4:       begin ma = su;  mb = sv;  end
      OP_RING_PROD0: begin ma = f;   mb = e;   end
      OP_RING_PROD1: begin ma = f;   mb = g;   end
      OP_CH:         begin ma = c;   mb = h;   end
      OP_CD:         begin ma = c;   mb = d;   end
      OP_LH:         begin ma = l;   mb = h;   end
      OP_DEN:        begin ma = ch;  mb = e;   end
      OP_T:          begin ma = ch;  mb = g;   end
      OP_TN:         begin ma = t;   mb = n;   end
      OP_PX:         begin ma = lh;  mb = m;   end
      OP_TM:         begin ma = t;   mb = m;   end
      OP_PY:         begin ma = lh;  mb = n;   end
      OP_L1:         begin ma = cd;  mb = g;   end
      OP_L3:         begin ma = la;  mb = m;   end
      OP_L4:         begin ma = cd;  mb = e;   end
      OP_L6:         begin ma = l;   mb = d;   end
      OP_L7:         begin ma = la;  mb = n;   end
      OP_XP:         begin ma = signed'(VW'(dq)); mb = px; end
      OP_YP:         begin ma = signed'(VW'(dq)); mb = py; end
      default:       begin ma = '0;  mb = '0;  end
    endcase
  end

  always_comb begin
    prod    = ma * mb;
    qm_full = (prod + ROUND_Q14) >>> 14;
    qm      = qm_full[VW-1:0];
    den_sum = qm + fg + DEN_OFF;
  end

  // sine phase and quarter fold
  always_comb begin
    case (cmd.tgt)
      TGT_E:   sin_phase = rot_a;
      TGT_G:   sin_phase = rot_a + QUARTER;
      TGT_N:   sin_phase = rot_b;
      TGT_M:   sin_phase = rot_b + QUARTER;
      TGT_D:   sin_phase = ring_ph + QUARTER;
      TGT_F:   sin_phase = ring_ph;
      TGT_C:   sin_phase = sweep_ph;
      TGT_L:   sin_phase = sweep_ph + QUARTER;
      default: sin_phase = rot_a;
    endcase
    sin_q = {1'b0, sin_phase[QUARTER_BITS-1:0]};
    if (sin_phase[QUARTER_BITS]) begin
      sin_q = QUARTER_V - sin_q;
    end
    sin_u   = signed'(VW'(sin_q) << U_SHIFT);
    sin_res = prod >>> 16;
    sin_r2  = VW'((sin_res + PW'(2)) >>> 2);
    if (sin_r2 > ONE_V) begin
      sin_r2 = ONE_V;
    end
    sin_val = squad[1] ? -sin_r2 : sin_r2;
  end

  // projection, screen test, lighting level, read address and angle step sums
  always_comb begin
    x_sum    = xp * X_MUL + X_BIAS;
    y_sum    = yp * Y_MUL + Y_BIAS;
    onscreen = (x > 0) && (x < X_LIM) && (y > 0) && (y < Y_LIM);
    look_addr = onscreen
              ? CELL_W'(x[COL_W-1:0]) + CELL_W'(COLUMNS) * CELL_W'(y[ROW_W-1:0])
              : '0;
    rd_oor   = in_data.cell_index >= 11'(CELLS);
    rd_addr  = rd_oor ? '0 : CELL_W'(in_data.cell_index);
    lum      = lb - la;
    lum_sh   = lum >>> LEVEL_SHIFT;
    if (lum <= 0) begin
      lvl_idx = '0;
    end else if (lum_sh > LVL_MAX) begin
      lvl_idx = LVL_MAX;
    end else begin
      lvl_idx = lum_sh;
    end
    ring_sum  = {1'b0, ring_rem} + (RR_W+1)'(RING_REM_INC);
    sweep_sum = {1'b0, sweep_rem} + (SR_W+1)'(SWEEP_REM_INC);
    lvl_out   = oor_q ? '0 : shade_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_a    <= '0;
      rot_b    <= '0;
      clr_addr <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_ROTATION_A) begin
        rot_a <= cfg_data[ANGLE_BITS-1:0];
      end
      if (cfg_write && cfg_index == REG_ROTATION_B) begin
        rot_b <= cfg_data[ANGLE_BITS-1:0];
      end
      if (cmd.op == OP_CLEAR) begin
        clr_addr <= (clr_addr == CELL_W'(CELLS - 1)) ? '0 : clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SIN0: begin
        su    <= sin_u;
        squad <= sin_phase[ANGLE_BITS-1 -: 2];
      end
      OP_SIN1: su2 <= VW'(prod >>> 16);
      OP_SIN2: sv  <= K1 - VW'(prod >>> 16);
      OP_SIN3: sv  <= K2 - VW'(prod >>> 16);
      OP_SIN4: begin
        case (cmd.tgt)
          TGT_E:   e <= sin_val;
          TGT_G:   g <= sin_val;
          TGT_N:   n <= sin_val;
          TGT_M:   m <= sin_val;
          TGT_D:   d <= sin_val;
          TGT_F:   f <= sin_val;
          TGT_C:   c <= sin_val;
          TGT_L:   l <= sin_val;
          default: e <= sin_val;
        endcase
      end
      OP_RING_START: begin
        ring_ph  <= '0;
        ring_rem <= '0;
      end
      OP_RING_STEP: begin
        if (ring_sum >= (RR_W+1)'(RING_STEPS)) begin
          ring_rem <= RR_W'(ring_sum - (RR_W+1)'(RING_STEPS));
          ring_ph  <= ring_ph + ANGLE_BITS'(RING_INC + 1);
        end else begin
          ring_rem <= RR_W'(ring_sum);
          ring_ph  <= ring_ph + ANGLE_BITS'(RING_INC);
        end
      end
      OP_SWEEP_START: begin
        sweep_ph  <= '0;
        sweep_rem <= '0;
      end
      OP_SWEEP_STEP: begin
        if (sweep_sum >= (SR_W+1)'(SWEEP_STEPS)) begin
          sweep_rem <= SR_W'(sweep_sum - (SR_W+1)'(SWEEP_STEPS));
          sweep_ph  <= sweep_ph + ANGLE_BITS'(SWEEP_INC + 1);
        end else begin
          sweep_rem <= SR_W'(sweep_sum);
          sweep_ph  <= sweep_ph + ANGLE_BITS'(SWEEP_INC);
        end
      end
      OP_RING_PROD0: begin
        h  <= d + TWO_V;
        fe <= qm;
      end
      OP_RING_PROD1: fg <= qm;
      OP_CH:  ch <= qm;
      OP_CD:  cd <= qm;
      OP_LH:  lh <= qm;
      OP_DEN: den <= (den_sum < 1) ? VW'(1) : den_sum;
      OP_T:   t  <= qm - fe;
      OP_TN:  ta <= qm;
      OP_PX:  px <= qm - ta;
      OP_TM:  ta <= qm;
      OP_PY:  py <= qm + ta;
      OP_L1:  la <= qm;
      OP_L2:  la <= fe - la;
      OP_L3:  lb <= qm;
      OP_L4:  la <= qm;
      OP_L5:  lb <= lb - la - fg;
      OP_L6:  la <= qm;
      OP_L7:  la <= qm;
      OP_L8:  lvl_q <= LEVEL_W'(lvl_idx) + 1'b1;
      OP_XP:  xp <= prod;
      OP_X:   x  <= x_sum[PW-1:POS_SHIFT];
      OP_YP:  yp <= prod;
      OP_Y:   y  <= y_sum[PW-1:POS_SHIFT];
      OP_LOOK: begin
        onscreen_q <= onscreen;
        cell_q     <= look_addr;
      end
      OP_READ: oor_q <= rd_oor;
      OP_EMIT: begin
        out_data.shade_level <= lvl_out;
        out_data.char_code   <= shade_char(lvl_out);
      end
      default: ;
    endcase
  end

  // depth and shade stores
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) begin
      depth_mem[clr_addr] <= '0;
      shade_mem[clr_addr] <= '0;
    end else if (cmd.op == OP_WRITE) begin
      depth_mem[cell_q] <= dq;
      shade_mem[cell_q] <= lvl_q;
    end
    if (cmd.op == OP_LOOK) begin
      depth_q <= depth_mem[look_addr];
    end
    if (cmd.op == OP_READ) begin
      shade_q <= shade_mem[rd_addr];
    end
  end

  always_comb begin
    status.clear_last = clr_addr == CELL_W'(CELLS - 1);
    status.div_busy   = div_busy;
    status.keep       = onscreen_q && (dq > depth_q);
  end

endmodule

`default_nettype wire

/* rtl/atzr_ctrl.sv */
// ----------------------------------------------------------------------------
// atzr_ctrl
// Sequencer: store clearing, frame/ring/point sweep, per-point operation
// order and the read handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module atzr_ctrl import atzr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_operation,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SIN,
    ST_RING_START, ST_RING_STEP, ST_RING_PROD0, ST_RING_PROD1,
    ST_SWEEP_START, ST_SWEEP_STEP,
    ST_CH, ST_CD, ST_LH, ST_DEN, ST_T, ST_TN, ST_PX, ST_TM, ST_PY,
    ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7, ST_L8,
    ST_WAIT, ST_XP, ST_X, ST_YP, ST_Y, ST_LOOK, ST_TEST, ST_WRITE, ST_NEXT
  } state_t;

  state_t             state, state_next;
  logic [2:0]         sub, sub_next;
  tgt_t               tgt, tgt_next;
  logic [RING_W-1:0]  ring, ring_next;
  logic [SWEEP_W-1:0] sweep, sweep_next;
  logic               busy, busy_next;
  logic               out_valid_next;
  logic               accept;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.tgt = tgt;
    case (state)
      ST_CLEAR:       cmd.op = OP_CLEAR;
      ST_IDLE:        cmd.op = (accept && in_operation == OPER_READ) ? OP_READ : OP_NONE;
      ST_READ:        cmd.op = OP_EMIT;
      ST_SIN: begin
        case (sub)
          3'd0:    cmd.op = OP_SIN0;
          3'd1:    cmd.op = OP_SIN1;
          3'd2:    cmd.op = OP_SIN2;
          3'd3:    cmd.op = OP_SIN3;
          default: cmd.op = OP_SIN4;
        endcase
      end
      ST_RING_START:  cmd.op = OP_RING_START;
      ST_RING_STEP:   cmd.op = OP_RING_STEP;
      ST_RING_PROD0:  cmd.op = OP_RING_PROD0;
      ST_RING_PROD1:  cmd.op = OP_RING_PROD1;
      ST_SWEEP_START: cmd.op = OP_SWEEP_START;
      ST_SWEEP_STEP:  cmd.op = OP_SWEEP_STEP;
      ST_CH:          cmd.op = OP_CH;
      ST_CD:          cmd.op = OP_CD;
      ST_LH:          cmd.op = OP_LH;
      ST_DEN:         cmd.op = OP_DEN;
      ST_T:           cmd.op = OP_T;
      ST_TN:          cmd.op = OP_TN;
      ST_PX:          cmd.op = OP_PX;
      ST_TM:          cmd.op = OP_TM;
      ST_PY:          cmd.op = OP_PY;
      ST_L1:          cmd.op = OP_L1;
      ST_L2:          cmd.op = OP_L2;
      ST_L3:          cmd.op = OP_L3;
      ST_L4:          cmd.op = OP_L4;
      ST_L5:          cmd.op = OP_L5;
      ST_L6:          cmd.op = OP_L6;
      ST_L7:          cmd.op = OP_L7;
      ST_L8:          cmd.op = OP_L8;
      ST_XP:          cmd.op = OP_XP;
      ST_X:           cmd.op = OP_X;
      ST_YP:          cmd.op = OP_YP;
      ST_Y:           cmd.op = OP_Y;
      ST_LOOK:        cmd.op = OP_LOOK;
      ST_WRITE:       cmd.op = OP_WRITE;
      default:        cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    state_next     = state;
    sub_next       = sub;
    tgt_next       = tgt;
    ring_next      = ring;
    sweep_next     = sweep;
    busy_next      = busy;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          if (busy) begin
            state_next = ST_SIN;
            sub_next   = '0;
            tgt_next   = TGT_E;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OPER_READ) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_CLEAR;
            busy_next  = 1'b1;
            ring_next  = '0;
            sweep_next = '0;
          end
        end
      end
      ST_READ: begin
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_SIN: begin
        sub_next = sub + 1'b1;
        if (sub == 3'd4) begin
          sub_next = '0;
          case (tgt)
            TGT_E:   tgt_next = TGT_G;
            TGT_G:   tgt_next = TGT_N;
            TGT_N:   tgt_next = TGT_M;
            TGT_M:   state_next = ST_RING_START;
            TGT_D:   tgt_next = TGT_F;
            TGT_F:   state_next = ST_RING_PROD0;
            TGT_C:   tgt_next = TGT_L;
            default: state_next = ST_CH;
          endcase
        end
      end
      ST_RING_START, ST_RING_STEP: begin
        state_next = ST_SIN;
        sub_next   = '0;
        tgt_next   = TGT_D;
      end
      ST_RING_PROD0:  state_next = ST_RING_PROD1;
      ST_RING_PROD1:  state_next = ST_SWEEP_START;
      ST_SWEEP_START, ST_SWEEP_STEP: begin
        state_next = ST_SIN;
        sub_next   = '0;
        tgt_next   = TGT_C;
      end
      ST_CH:  state_next = ST_CD;
      ST_CD:  state_next = ST_LH;
      ST_LH:  state_next = ST_DEN;
      ST_DEN: state_next = ST_T;
      ST_T:   state_next = ST_TN;
      ST_TN:  state_next = ST_PX;
      ST_PX:  state_next = ST_TM;
      ST_TM:  state_next = ST_PY;
      ST_PY:  state_next = ST_L1;
      ST_L1:  state_next = ST_L2;
      ST_L2:  state_next = ST_L3;
      ST_L3:  state_next = ST_L4;
      ST_L4:  state_next = ST_L5;
      ST_L5:  state_next = ST_L6;
      ST_L6:  state_next = ST_L7;
      ST_L7:  state_next = ST_L8;
      ST_L8:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (!status.div_busy) begin
          state_next = ST_XP;
        end
      end
      ST_XP:   state_next = ST_X;
      ST_X:    state_next = ST_YP;
      ST_YP:   state_next = ST_Y;
      ST_Y:    state_next = ST_LOOK;
      ST_LOOK: state_next = ST_TEST;
      ST_TEST: state_next = status.keep ? ST_WRITE : ST_NEXT;
      ST_WRITE: state_next = ST_NEXT;
      ST_NEXT: begin
        if (sweep == SWEEP_W'(SWEEP_STEPS - 1)) begin
          sweep_next = '0;
          if (ring == RING_W'(RING_STEPS - 1)) begin
            ring_next  = '0;
            busy_next  = 1'b0;
            state_next = ST_IDLE;
          end else begin
            ring_next  = ring + 1'b1;
            state_next = ST_RING_STEP;
          end
        end else begin
          sweep_next = sweep + 1'b1;
          state_next = ST_SWEEP_STEP;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sub       <= '0;
      tgt       <= TGT_E;
      ring      <= '0;
      sweep     <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sub       <= sub_next;
      tgt       <= tgt_next;
      ring      <= ring_next;
      sweep     <= sweep_next;
      busy      <= busy_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/atzr_checker.sv */
// ----------------------------------------------------------------------------
// atzr_checker
// Port-level checks of the torus renderer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module atzr_checker import atzr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `CHK_IMPLY(a_level_range, clk, rst, out_valid, out_data.shade_level <= 4'd12)
  `CHK_IMPLY(a_blank_char, clk, rst, out_valid && out_data.shade_level == 4'd0, out_data.char_code == 7'd32)
  `CHK_IMPLY(a_read_answer, clk, rst, in_valid && in_ready && in_data.operation == OPER_READ, ##2 out_valid)
  `CHK_IMPLY(a_clear_after_reset, clk, rst, $fell(rst), !in_ready)

endmodule

bind ascii_torus_zbuffer_render_top atzr_checker u_chk (.*);

`default_nettype wire

/* sim/ascii_torus_zbuffer_render_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_torus_zbuffer_render_top_tb
// Drives render and cell-read beats into the torus renderer with and without
// random idling on both channels and checks every read beat against a
// fixed-point model of the frame held in the bench or a value from the
// stimulus table, with angle settings changed between frames.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_torus_zbuffer_render_top_tb;
  import atzr_pkg::*;

  localparam int STALL_LIMIT = 6000000;
  localparam int RAND_READS  = 25;

  typedef struct {
    bit          oper;
    int          addr;
    bit          typed;
    int          char_exp;
    int          level_exp;
    int          angle_a;
    int          angle_b;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_write;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ascii_torus_zbuffer_render_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bit [15:0]  depth_model [CELLS];
  bit [3:0]   shade_model [CELLS];
  bit [11:0]  tilt_angle;
  bit [11:0]  spin_angle;
  out_item_t  pending_reads[$];
  int         mismatches;
  int         stall_count;
  int         send_idle;
  int         recv_idle;
  stim_row_t  stim_table[$];

  function automatic longint qmul(longint a, longint b);
    return (a * b + 8192) >>> 14;
  endfunction

  function automatic longint sine_q14(int phase);
    int     p;
    int     quad;
    longint q;
    longint u;
    longint u2;
    longint inner;
    longint mid;
    longint v;
    p = phase & ((1 << ANGLE_BITS) - 1);
    quad = (p >> QUARTER_BITS) & 3;
    q = p & ((1 << QUARTER_BITS) - 1);
    if (quad & 1) q = (1 << QUARTER_BITS) - q;
    u = q << (16 - QUARTER_BITS);
    u2 = (u * u) >> 16;
    inner = 42334 - ((4926 * u2) >> 16);
    mid = 102944 - ((u2 * inner) >> 16);
    v = (((u * mid) >> 16) + 2) >> 2;
    if (v > ONE_Q14) v = ONE_Q14;
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic longint cosine_q14(int phase);
    return sine_q14(phase + (1 << QUARTER_BITS));
  endfunction

  function automatic void draw_frame();
    longint e, g, n, m, d, f, h, fe, fg, c, l, ch, cd, lh, den, dq, t, px, py;
    longint x, y, lum, lvl;
    int     addr;
    e = sine_q14(tilt_angle);
    g = cosine_q14(tilt_angle);
    n = sine_q14(spin_angle);
    m = cosine_q14(spin_angle);
    for (int i = 0; i < CELLS; i++) begin
      depth_model[i] = 0;
      shade_model[i] = 0;
    end
    for (int r = 0; r < RING_STEPS; r++) begin
      d = cosine_q14((r << ANGLE_BITS) / RING_STEPS);
      f = sine_q14((r << ANGLE_BITS) / RING_STEPS);
      h = d + 2 * ONE_Q14;
      fe = qmul(f, e);
      fg = qmul(f, g);
      for (int s = 0; s < SWEEP_STEPS; s++) begin
        c = sine_q14((s << ANGLE_BITS) / SWEEP_STEPS);
        l = cosine_q14((s << ANGLE_BITS) / SWEEP_STEPS);
        ch = qmul(c, h);
        cd = qmul(c, d);
        lh = qmul(l, h);
        den = qmul(ch, e) + fg + DEPTH_OFFSET * ONE_Q14;
        if (den < 1) den = 1;
        dq = (64'sd1 << 30) / den;
        if (dq > 65535) dq = 65535;
        t = qmul(ch, g) - fe;
        px = qmul(lh, m) - qmul(t, n);
        py = qmul(lh, n) + qmul(t, m);
        x = ((longint'(X_CENTER) << 30) + X_SCALE * dq * px) >>> 30;
        y = ((longint'(Y_CENTER) << 30) + Y_SCALE * dq * py) >>> 30;
        if (!(y > 0 && y < ROWS && x > 0 && x < COLUMNS)) continue;
        addr = int'(x) + COLUMNS * int'(y);
        if (dq <= depth_model[addr]) continue;
        lum = qmul(fe - qmul(cd, g), m) - qmul(cd, e) - fg - qmul(qmul(l, d), n);
        lvl = (lum > 0) ? (lum >>> 11) : 0;
        if (lvl > 11) lvl = 11;
        depth_model[addr] = dq[15:0];
        shade_model[addr] = lvl[3:0] + 4'd1;
      end
    end
  endfunction

  function automatic out_item_t cell_char(int addr);
    string     ramp;
    out_item_t o;
    ramp = ".,-~:;=!*#$@";
    o.shade_level = (addr < CELLS) ? shade_model[addr] : 4'd0;
    o.char_code = (o.shade_level == 0) ? 7'd32 : 7'(ramp[o.shade_level - 1]);
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("beat mismatch on %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  task automatic write_angles(int a, int b);
    while (pending_reads.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = REG_ROTATION_A;
    cfg_data = a[CFG_W-1:0];
    tilt_angle = a[11:0];
    @(negedge clk);
    cfg_index = REG_ROTATION_B;
    cfg_data = b[CFG_W-1:0];
    spin_angle = b[11:0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic send_beat(stim_row_t row);
    out_item_t o;
    if (row.oper == OPER_RENDER) write_angles(row.angle_a, row.angle_b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) @(negedge clk);
    in_valid = 1'b1;
    in_data.operation = row.oper;
    in_data.cell_index = row.addr[10:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (row.oper == OPER_RENDER) begin
      draw_frame();
    end else begin
      o = cell_char(row.addr);
      if (row.typed) begin
        o.char_code = row.char_exp[6:0];
        o.shade_level = row.level_exp[3:0];
      end
      pending_reads.push_back(o);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic stim_row_t make_row(bit oper, int addr, bit typed, int ch, int lvl,
                                         int a, int b);
    stim_row_t row;
    row.oper = oper;
    row.addr = addr;
    row.typed = typed;
    row.char_exp = ch;
    row.level_exp = lvl;
    row.angle_a = a;
    row.angle_b = b;
    return row;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (recv_idle == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        report("unexpected read beat", 1, 0);
      end else begin
        want = pending_reads.pop_front();
        if (out_data.char_code !== want.char_code)
          report("char_code", out_data.char_code, want.char_code);
        if (out_data.shade_level !== want.shade_level)
          report("shade_level", out_data.shade_level, want.shade_level);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int phase_a [3];
    int phase_b [3];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = REG_ROTATION_A;
    cfg_data = '0;
    out_ready = 1'b0;
    mismatches = 0;
    stall_count = 0;
    tilt_angle = 0;
    spin_angle = 0;
    send_idle = 13;
    recv_idle = 68;
    for (int i = 0; i < CELLS; i++) begin
      depth_model[i] = 0;
      shade_model[i] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // blank stores after reset, out-of-range cells, then a frame at zero angles and reads of it
    stim_table.push_back(make_row(OPER_READ, 0, 1, 32, 0, 0, 0));
    stim_table.push_back(make_row(OPER_READ, 1000, 1, 32, 0, 0, 0));
    stim_table.push_back(make_row(OPER_READ, 1759, 1, 32, 0, 0, 0));
    stim_table.push_back(make_row(OPER_READ, 1760, 1, 32, 0, 0, 0));
    stim_table.push_back(make_row(OPER_READ, 2047, 1, 32, 0, 0, 0));
    stim_table.push_back(make_row(OPER_RENDER, 2047, 0, 0, 0, 0, 0));
    stim_table.push_back(make_row(OPER_READ, 0, 1, 32, 0, 0, 0));
    stim_table.push_back(make_row(OPER_READ, 2047, 1, 32, 0, 0, 0));
    stim_table.push_back(make_row(OPER_READ, 1760, 1, 32, 0, 0, 0));
    for (int i = 0; i < 12; i++)
      stim_table.push_back(make_row(OPER_READ, 40 + COLUMNS * (i + 6) - 20 + 3 * i,
                                    0, 0, 0, 0, 0));
    stim_table.push_back(make_row(OPER_READ, 1759, 0, 0, 0, 0, 0));
    foreach (stim_table[i]) send_beat(stim_table[i]);

    phase_a[0] = 4095; phase_b[0] = 4095;
    phase_a[1] = $urandom_range(0, 4095); phase_b[1] = $urandom_range(0, 4095);
    phase_a[2] = 1024; phase_b[2] = 3072;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 13 : (ph == 1) ? 68 : 0;
      recv_idle = (ph == 0) ? 68 : (ph == 1) ? 13 : 0;
      send_beat(make_row(OPER_RENDER, $urandom_range(0, 2047), 0, 0, 0,
                         phase_a[ph], phase_b[ph]));
      for (int k = 0; k < RAND_READS; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_beat(make_row(OPER_READ, $urandom_range(0, 2047), 0, 0, 0, 0, 0));
        else
          send_beat(make_row(OPER_READ, $urandom_range(COLUMNS, CELLS - 1), 0, 0, 0, 0, 0));
      end
    end

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
